// File: rtl/fdm_pkg.sv
// Package: shared types, constants and helpers for the directory entry name matcher.
`timescale 1ns / 1ps

package fdm_pkg;

    localparam int MAX_NAME_CHARS = 16;
    localparam int NAME_LEN_8_3   = 11;
    localparam int TLEN_W         = 5;
    localparam int EIDX_W         = 4;

    localparam logic [7:0] ENTRY_DELETED  = 8'hE5;
    localparam logic [7:0] ATTR_LONG_NAME = 8'h0F;
    localparam logic [7:0] ATTR_VOL_ID    = 8'(1 << 3);
    localparam logic [7:0] ATTR_SYSTEM    = 8'(1 << 2);
    localparam logic [7:0] ATTR_DIR       = 8'(1 << 4);
    localparam logic [7:0] CHAR_DOT       = 8'h2E;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_LOW_A     = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z     = 8'h7A;
    localparam logic [7:0] CASE_OFFSET    = 8'h20;

    typedef enum logic [1:0] {
        CFG_NAME_LOW  = 2'd0,
        CFG_NAME_HIGH = 2'd1,
        CFG_NAME_LEN  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_MATCH    = 2'd1,
        ST_END      = 2'd2,
        ST_FINISHED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_MATCH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic classify;
        logic step;
        logic conclude;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pre_final;
        logic match_over;
    } dp_stat_t;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z)
        begin
            r = c - CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// File: rtl/fdm_in_if.sv
// Interface: input channel carrying one directory entry word.
`timescale 1ns / 1ps

interface fdm_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] entry_name_low;
    logic [23:0] entry_name_high;
    logic [7:0]  entry_attributes;
    logic [15:0] cluster_high_half;
    logic [15:0] cluster_low_half;
    logic [31:0] entry_size_bytes;
    logic        start_new_search;

    modport source (
        output valid, entry_name_low, entry_name_high, entry_attributes,
               cluster_high_half, cluster_low_half, entry_size_bytes, start_new_search,
        input  ready
    );
    modport sink (
        input  valid, entry_name_low, entry_name_high, entry_attributes,
               cluster_high_half, cluster_low_half, entry_size_bytes, start_new_search,
        output ready
    );
endinterface

// File: rtl/fdm_out_if.sv
// Interface: output channel carrying one search result word.
`timescale 1ns / 1ps

interface fdm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  search_status;
    logic [31:0] first_cluster;
    logic [31:0] found_file_size;

    modport source (
        output valid, search_status, first_cluster, found_file_size,
        input  ready
    );
    modport sink (
        input  valid, search_status, first_cluster, found_file_size,
        output ready
    );
endinterface

// File: rtl/fdm_ctrl.sv
// Controller: sequences load, classification, name compare steps and result hand-off.
`timescale 1ns / 1ps

module fdm_ctrl
    import fdm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = stat.pre_final ? S_DONE : S_MATCH;
            end
            S_MATCH:
            begin
                if (stat.match_over)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
            end
            S_CHECK:
            begin
                cmd.classify = 1'b1;
            end
            S_MATCH:
            begin
                cmd.step     = 1'b1;
                cmd.conclude = stat.match_over;
            end
            S_DONE:
            begin
                cmd.emit = !out_valid_reg || out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Drop output valid once taken, raise it on a new result
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: rtl/fdm_dp.sv
// Datapath: target registers, entry capture, stepwise 8.3 compare and result register.
`timescale 1ns / 1ps

module fdm_dp
    import fdm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic [63:0] entry_name_low,
    input  logic [23:0] entry_name_high,
    input  logic [7:0]  entry_attributes,
    input  logic [15:0] cluster_high_half,
    input  logic [15:0] cluster_low_half,
    input  logic [31:0] entry_size_bytes,
    input  logic        start_new_search,
    input  ctrl_cmd_t   cmd,
    output dp_stat_t    stat,
    output logic [1:0]  search_status,
    output logic [31:0] first_cluster,
    output logic [31:0] found_file_size
);

    logic [63:0]             tname_low_reg;
    logic [63:0]             tname_high_reg;
    logic [TLEN_W-1:0]       tname_len_reg;
    logic                    finished_reg;

    logic [NAME_LEN_8_3-1:0][7:0]   ent_reg;
    logic [7:0]              attr_reg;
    logic [31:0]             cluster_reg;
    logic [31:0]             size_reg;
    logic [EIDX_W-1:0]       i_reg;
    logic [TLEN_W-1:0]       j_reg;
    logic [TLEN_W-1:0]       len_reg;
    status_t                 res_reg;

    logic [1:0]              out_status_reg;
    logic [31:0]             out_cluster_reg;
    logic [31:0]             out_size_reg;

    logic [MAX_NAME_CHARS-1:0][7:0] tchars;
    logic [TLEN_W-1:0]       lim;
    logic [TLEN_W-1:0]       len_calc;
    logic                    is_end;
    logic                    is_skip;
    logic                    run;
    logic [7:0]              t_ch;
    logic [7:0]              e_ch;
    logic                    ch_eq;
    logic                    ch_fail;
    logic                    match_ok;

    assign tchars = {tname_high_reg, tname_low_reg};

    // Saturate the length and cut it at the first zero character
    always_comb
    begin
        lim = (tname_len_reg > TLEN_W'(MAX_NAME_CHARS)) ? TLEN_W'(MAX_NAME_CHARS)
                                                        : tname_len_reg;
        len_calc = lim;
        for (int k = MAX_NAME_CHARS - 1; k >= 0; k--)
        begin
            if (TLEN_W'(k) < lim && tchars[k] == 8'h00)
            begin
                len_calc = TLEN_W'(k);
            end
        end
    end

    // Classify the captured entry
    assign is_end  = (ent_reg[0] == 8'h00);
    assign is_skip = (ent_reg[0] == ENTRY_DELETED) || (attr_reg == ATTR_LONG_NAME) ||
                     (attr_reg == ATTR_VOL_ID) || (attr_reg == ATTR_SYSTEM) ||
                     (attr_reg == ATTR_DIR);

    // One compare step: pick the current characters
    assign run      = (i_reg < EIDX_W'(NAME_LEN_8_3)) && (j_reg < len_reg);
    assign t_ch     = tchars[j_reg[EIDX_W-1:0]];
    assign e_ch     = (i_reg < EIDX_W'(NAME_LEN_8_3)) ? ent_reg[i_reg] : 8'h00;
    assign ch_eq    = (upcase(t_ch) == upcase(e_ch));
    assign ch_fail  = !ch_eq && (t_ch != CHAR_DOT) && (e_ch != CHAR_SPACE);
    assign match_ok = !run && (j_reg == len_reg) && (i_reg == EIDX_W'(NAME_LEN_8_3));

    assign stat.pre_final  = finished_reg || is_end || is_skip;
    assign stat.match_over = !run || ch_fail;

    // Configuration registers and the finished flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tname_low_reg  <= '0;
            tname_high_reg <= '0;
            tname_len_reg  <= '0;
            finished_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_NAME_LOW:  tname_low_reg  <= cfg_data;
                    CFG_NAME_HIGH: tname_high_reg <= cfg_data;
                    CFG_NAME_LEN:  tname_len_reg  <= cfg_data[TLEN_W-1:0];
                    default:       tname_len_reg  <= tname_len_reg;
                endcase
            end
            if (cmd.load && start_new_search)
            begin
                finished_reg <= 1'b0;
            end
            else if (cmd.classify && !finished_reg && is_end)
            begin
                finished_reg <= 1'b1;
            end
            else if (cmd.conclude && match_ok)
            begin
                finished_reg <= 1'b1;
            end
        end
    end

    // Capture the entry, walk the names, settle the result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ent_reg     <= {entry_name_high, entry_name_low};
            attr_reg    <= entry_attributes;
            cluster_reg <= {cluster_high_half, cluster_low_half};
            size_reg    <= entry_size_bytes;
            i_reg       <= '0;
            j_reg       <= '0;
            len_reg     <= len_calc;
        end
        if (cmd.classify)
        begin
            priority if (finished_reg)
            begin
                res_reg <= ST_FINISHED;
            end
            else if (is_end)
            begin
                res_reg <= ST_END;
            end
            else
            begin
                res_reg <= ST_NONE;
            end
        end
        if (cmd.step && run)
        begin
            priority if (ch_eq)
            begin
                i_reg <= i_reg + 1'b1;
                j_reg <= j_reg + 1'b1;
            end
            else if (t_ch == CHAR_DOT)
            begin
                j_reg <= j_reg + 1'b1;
            end
            else if (e_ch == CHAR_SPACE)
            begin
                i_reg <= i_reg + 1'b1;
            end
            else
            begin
                i_reg <= i_reg;
            end
        end
        if (cmd.conclude)
        begin
            res_reg <= match_ok ? ST_MATCH : ST_NONE;
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status_reg  <= res_reg;
            out_cluster_reg <= (res_reg == ST_MATCH) ? cluster_reg : 32'd0;
            out_size_reg    <= (res_reg == ST_MATCH) ? size_reg : 32'd0;
        end
    end

    assign search_status   = out_status_reg;
    assign first_cluster   = out_cluster_reg;
    assign found_file_size = out_size_reg;

endmodule

// File: rtl/fat_dir_entry_name_matcher_top.sv
// Top level: FAT32 directory entry 8.3 name matcher.
`timescale 1ns / 1ps

// Takes one directory entry word at a time and returns exactly one result word for it.
// An entry is accepted only while the block is idle. It is then classified (end marker,
// skipped entry, search already finished). A candidate entry then runs the character
// compare loop at one step per cycle. Entry and target indices advance by at least one
// between them per step until a mismatch. The loop ends on a mismatch or once the 11
// entry bytes or the target characters (at most 16) are used up; a closing step then
// settles the result. The result goes to the output register once an earlier word
// there, if any, has been taken. The block is idle again in the cycle after the result
// is written, so the next entry can be accepted while that result may still wait in
// the output register. Configuration writes are taken any time the block holds no
// unfinished entry.

module fat_dir_entry_name_matcher_top
    import fdm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    fdm_in_if.sink      in_ch,
    fdm_out_if.source   out_ch
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // Sequencer
    fdm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Compare datapath
    fdm_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .entry_name_low    (in_ch.entry_name_low),
        .entry_name_high   (in_ch.entry_name_high),
        .entry_attributes  (in_ch.entry_attributes),
        .cluster_high_half (in_ch.cluster_high_half),
        .cluster_low_half  (in_ch.cluster_low_half),
        .entry_size_bytes  (in_ch.entry_size_bytes),
        .start_new_search  (in_ch.start_new_search),
        .cmd               (cmd),
        .stat              (stat),
        .search_status     (out_ch.search_status),
        .first_cluster     (out_ch.first_cluster),
        .found_file_size   (out_ch.found_file_size)
    );

endmodule

// File: rtl/fdm_checker.sv
// Checker: port-level properties of the name matcher, bound to the top level.
`timescale 1ns / 1ps

module fdm_checker
    import fdm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  search_status,
    input logic [31:0] first_cluster,
    input logic [31:0] found_file_size
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(search_status))
        else $error("output word changed while stalled");

    // Clear cluster and size on anything but a match
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && search_status != ST_MATCH |-> first_cluster == 32'd0 &&
        found_file_size == 32'd0)
        else $error("non-match result carries cluster or size");

    // Take one entry at a time
    a_one_entry: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("new entry taken while one is in work");

endmodule

bind fat_dir_entry_name_matcher_top fdm_checker u_fdm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .search_status   (out_ch.search_status),
    .first_cluster   (out_ch.first_cluster),
    .found_file_size (out_ch.found_file_size)
);
